// ===== design/gte_pkg.sv =====
// Shared constants for the graph traversal engine: command codes, status codes
// and fixed field widths. No dependencies.
`timescale 1ns / 1ps

package gte_pkg;

    // Widths fixed by the word format
    localparam int VW    = 6;
    localparam int CFG_W = 7;
    localparam int CMD_W = 2;
    localparam int ST_W  = 2;

    // Vertex indices are six bits wide, so no more than this many are ever live
    localparam int VX_LIMIT = 64;

    localparam logic [CFG_W-1:0] VC_RESET = 7'd64;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BFS  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DFS  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PATH = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== design/gte_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module gte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/graph_traversal_engine_top.sv =====
// Graph traversal engine: neighbour lists, BFS/DFS walks and path queries.
// A walk or a path query first clears the visited marks of MAX_VERTICES (capped at 64) vertices,
// then reads the neighbour table entry by entry and visits each vertex it reaches.
// Throughput: one command at a time; the neighbour table read port sets the walk speed.
// Reset (synchronous, active low): degrees read as zero, vertex_count 64, neighbours undefined.
`timescale 1ns / 1ps

module graph_traversal_engine_top #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_DEGREE   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gte_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [gte_pkg::CMD_W-1:0]   i_command,
    input  logic [gte_pkg::VW-1:0]      i_vertex_a,
    input  logic [gte_pkg::VW-1:0]      i_vertex_b,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [gte_pkg::VW-1:0]      o_visited_vertex,
    output logic                        o_path_found,
    output logic [gte_pkg::ST_W-1:0]    o_status,
    output logic                        o_last
);

    localparam int NV  = (MAX_VERTICES < gte_pkg::VX_LIMIT) ? MAX_VERTICES : gte_pkg::VX_LIMIT;
    localparam int VAW = $clog2(NV);
    localparam int DW  = $clog2(MAX_DEGREE + 1);
    localparam int NAW = $clog2(NV * MAX_DEGREE);
    localparam int SW  = VAW + DW;
    localparam int VW  = gte_pkg::VW;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_ADD_RA  = 5'd1;
    localparam logic [4:0] S_ADD_RB  = 5'd2;
    localparam logic [4:0] S_ADD_W1  = 5'd3;
    localparam logic [4:0] S_ADD_W2  = 5'd4;
    localparam logic [4:0] S_CLR     = 5'd5;
    localparam logic [4:0] S_B_INIT  = 5'd6;
    localparam logic [4:0] S_BQ_RD   = 5'd7;
    localparam logic [4:0] S_BQ_F    = 5'd8;
    localparam logic [4:0] S_BQ_DEG  = 5'd9;
    localparam logic [4:0] S_BN_RD   = 5'd10;
    localparam logic [4:0] S_BN_NB   = 5'd11;
    localparam logic [4:0] S_BN_VIS  = 5'd12;
    localparam logic [4:0] S_D_START = 5'd13;
    localparam logic [4:0] S_D_DEG   = 5'd14;
    localparam logic [4:0] S_D_TOP   = 5'd15;
    localparam logic [4:0] S_D_NB    = 5'd16;
    localparam logic [4:0] S_D_VIS   = 5'd17;
    localparam logic [4:0] S_D_POP   = 5'd18;
    localparam logic [4:0] S_FIN     = 5'd19;

    function automatic logic [NAW-1:0] nt_addr(input logic [VAW-1:0] v, input logic [DW-1:0] s);
        nt_addr = NAW'(v) * NAW'(MAX_DEGREE) + NAW'(s);
    endfunction

    // Control registers
    logic [4:0]               r_st, n_st;
    logic [gte_pkg::CFG_W-1:0] r_vc;
    logic [NV-1:0]            r_deg_vld, n_deg_vld;
    logic                     r_pv, n_pv;
    logic                     r_ov;
    // Working registers
    logic [gte_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [VW-1:0]            r_a, n_a, r_b, n_b;
    logic                     r_path, n_path;
    logic [DW-1:0]            r_da, n_da, r_db, n_db;
    logic [VAW-1:0]           r_cnt, n_cnt;
    logic [VAW:0]             r_head, n_head, r_tail, n_tail, r_sp, n_sp;
    logic [VAW-1:0]           r_f, n_f, r_nb, n_nb, r_tv, n_tv;
    logic [DW-1:0]            r_deg, n_deg, r_j, n_j, r_ts, n_ts;
    logic [VW-1:0]            r_pend, n_pend, r_fv, n_fv;
    logic                     r_ff, n_ff;
    logic [gte_pkg::ST_W-1:0] r_fs, n_fs;
    // Output word register
    logic [VW-1:0]            r_o_vert;
    logic                     r_o_found, r_o_last;
    logic [gte_pkg::ST_W-1:0] r_o_stat;

    // Emission of one result word
    logic                     e_en, e_found, e_last;
    logic [VW-1:0]            e_vert;
    logic [gte_pkg::ST_W-1:0] e_stat;

    // RAM ports
    logic             nt_we, nt_re;
    logic [NAW-1:0]   nt_waddr, nt_raddr;
    logic [VW-1:0]    nt_wdata, nt_rdata;
    logic             dg_we, dg_re;
    logic [VAW-1:0]   dg_waddr, dg_raddr;
    logic [DW-1:0]    dg_wdata, dg_rdata;
    logic             vs_we, vs_re;
    logic [VAW-1:0]   vs_waddr, vs_raddr;
    logic             vs_wdata, vs_rdata;
    logic             qu_we, qu_re;
    logic [VAW-1:0]   qu_waddr, qu_raddr;
    logic [VW-1:0]    qu_wdata, qu_rdata;
    logic             sk_we, sk_re;
    logic [VAW-1:0]   sk_waddr, sk_raddr;
    logic [SW-1:0]    sk_wdata, sk_rdata;

    logic [gte_pkg::CFG_W-1:0] w_n;
    logic                      w_out_free;
    logic [VAW:0]              w_sp_m1, w_sp_m2;
    logic [DW:0]               w_need, w_db_rd;
    logic [VAW-1:0]            w_src;

    assign w_n        = (r_vc > gte_pkg::CFG_W'(NV)) ? gte_pkg::CFG_W'(NV) : r_vc;
    assign w_out_free = !r_ov || i_out_ready;
    assign w_sp_m1    = r_sp - (VAW + 1)'(1);
    assign w_sp_m2    = r_sp - (VAW + 1)'(2);
    assign w_need     = (r_a == r_b) ? (DW + 1)'(2) : (DW + 1)'(1);
    assign w_db_rd    = (r_a == r_b) ? {1'b0, r_da} :
                        {1'b0, (r_deg_vld[r_b[VAW-1:0]] ? dg_rdata : DW'(0))};
    assign w_src      = r_path ? r_a[VAW-1:0] : VAW'(0);
    assign o_in_ready = (r_st == S_IDLE);

    // Sequencer: next state, memory accesses and result words
    always_comb begin
        n_st = r_st; n_deg_vld = r_deg_vld; n_pv = r_pv;
        n_cmd = r_cmd; n_a = r_a; n_b = r_b; n_path = r_path;
        n_da = r_da; n_db = r_db; n_cnt = r_cnt;
        n_head = r_head; n_tail = r_tail; n_sp = r_sp;
        n_f = r_f; n_nb = r_nb; n_tv = r_tv;
        n_deg = r_deg; n_j = r_j; n_ts = r_ts;
        n_pend = r_pend; n_fv = r_fv; n_ff = r_ff; n_fs = r_fs;
        e_en = 1'b0; e_vert = '0; e_found = 1'b0; e_stat = gte_pkg::ST_OK; e_last = 1'b0;
        nt_we = 1'b0; nt_re = 1'b0; nt_waddr = '0; nt_raddr = '0; nt_wdata = '0;
        dg_we = 1'b0; dg_re = 1'b0; dg_waddr = '0; dg_raddr = '0; dg_wdata = '0;
        vs_we = 1'b0; vs_re = 1'b0; vs_waddr = '0; vs_raddr = '0; vs_wdata = 1'b0;
        qu_we = 1'b0; qu_re = 1'b0; qu_waddr = '0; qu_raddr = '0; qu_wdata = '0;
        sk_we = 1'b0; sk_re = 1'b0; sk_waddr = '0; sk_raddr = '0; sk_wdata = '0;

        unique case (r_st)
            S_IDLE: begin
                n_fv = '0; n_ff = 1'b0; n_fs = gte_pkg::ST_OK; n_cnt = '0; n_pv = 1'b0;
                if (i_in_valid) begin
                    n_cmd = i_command; n_a = i_vertex_a; n_b = i_vertex_b;
                    unique case (i_command)
                        gte_pkg::CMD_ADD: begin
                            if ({1'b0, i_vertex_a} >= w_n || {1'b0, i_vertex_b} >= w_n) begin
                                n_fs = gte_pkg::ST_RANGE; n_st = S_FIN;
                            end else begin
                                dg_re = 1'b1; dg_raddr = i_vertex_a[VAW-1:0];
                                n_st = S_ADD_RA;
                            end
                        end
                        gte_pkg::CMD_BFS, gte_pkg::CMD_DFS: begin
                            n_path = 1'b0;
                            if (w_n == '0) begin
                                n_fs = gte_pkg::ST_RANGE; n_st = S_FIN;
                            end else begin
                                n_st = S_CLR;
                            end
                        end
                        default: begin
                            n_path = 1'b1;
                            if ({1'b0, i_vertex_a} >= w_n) begin
                                n_fs = gte_pkg::ST_RANGE; n_st = S_FIN;
                            end else if ({1'b0, i_vertex_b} >= w_n) begin
                                n_st = S_FIN;
                            end else if (i_vertex_a == i_vertex_b) begin
                                n_ff = 1'b1; n_st = S_FIN;
                            end else begin
                                n_st = S_CLR;
                            end
                        end
                    endcase
                end
            end
            // Add edge: fetch both degrees, check room, append both ways
            S_ADD_RA: begin
                n_da = r_deg_vld[r_a[VAW-1:0]] ? dg_rdata : DW'(0);
                dg_re = 1'b1; dg_raddr = r_b[VAW-1:0];
                n_st = S_ADD_RB;
            end
            S_ADD_RB: begin
                if ({1'b0, r_da} + w_need > (DW + 1)'(MAX_DEGREE) ||
                    w_db_rd + w_need > (DW + 1)'(MAX_DEGREE)) begin
                    n_fs = gte_pkg::ST_FULL; n_st = S_FIN;
                end else begin
                    n_db = (r_a == r_b) ? r_da + DW'(1) : w_db_rd[DW-1:0];
                    n_st = S_ADD_W1;
                end
            end
            S_ADD_W1: begin
                nt_we = 1'b1; nt_waddr = nt_addr(r_a[VAW-1:0], r_da); nt_wdata = r_b;
                dg_we = 1'b1; dg_waddr = r_a[VAW-1:0]; dg_wdata = r_da + DW'(1);
                n_deg_vld[r_a[VAW-1:0]] = 1'b1;
                n_st = S_ADD_W2;
            end
            S_ADD_W2: begin
                nt_we = 1'b1; nt_waddr = nt_addr(r_b[VAW-1:0], r_db); nt_wdata = r_a;
                dg_we = 1'b1; dg_waddr = r_b[VAW-1:0]; dg_wdata = r_db + DW'(1);
                n_deg_vld[r_b[VAW-1:0]] = 1'b1;
                n_st = S_FIN;
            end
            // Clear the visited marks, one entry a cycle
            S_CLR: begin
                vs_we = 1'b1; vs_waddr = r_cnt; vs_wdata = 1'b0;
                n_cnt = r_cnt + VAW'(1);
                if (r_cnt == VAW'(NV - 1)) begin
                    n_st = (r_cmd == gte_pkg::CMD_BFS) ? S_B_INIT : S_D_START;
                end
            end
            // Breadth-first walk
            S_B_INIT: begin
                vs_we = 1'b1; vs_waddr = '0; vs_wdata = 1'b1;
                qu_we = 1'b1; qu_waddr = '0; qu_wdata = '0;
                n_head = '0; n_tail = (VAW + 1)'(1);
                n_st = S_BQ_RD;
            end
            S_BQ_RD: begin
                if (r_head == r_tail) begin
                    n_fv = r_pend; n_st = S_FIN;
                end else begin
                    qu_re = 1'b1; qu_raddr = r_head[VAW-1:0];
                    n_head = r_head + (VAW + 1)'(1);
                    n_st = S_BQ_F;
                end
            end
            S_BQ_F: begin
                if (!(r_pv && !w_out_free)) begin
                    if (r_pv) begin
                        e_en = 1'b1; e_vert = r_pend;
                    end
                    n_pend = qu_rdata; n_pv = 1'b1;
                    n_f = qu_rdata[VAW-1:0];
                    dg_re = 1'b1; dg_raddr = qu_rdata[VAW-1:0];
                    n_st = S_BQ_DEG;
                end
            end
            S_BQ_DEG: begin
                n_deg = r_deg_vld[r_f] ? dg_rdata : DW'(0);
                n_j = '0;
                n_st = S_BN_RD;
            end
            S_BN_RD: begin
                if (r_j < r_deg) begin
                    nt_re = 1'b1; nt_raddr = nt_addr(r_f, r_j);
                    n_j = r_j + DW'(1);
                    n_st = S_BN_NB;
                end else begin
                    n_st = S_BQ_RD;
                end
            end
            S_BN_NB: begin
                n_nb = nt_rdata[VAW-1:0];
                if ({1'b0, nt_rdata} < w_n) begin
                    vs_re = 1'b1; vs_raddr = nt_rdata[VAW-1:0];
                    n_st = S_BN_VIS;
                end else begin
                    n_st = S_BN_RD;
                end
            end
            S_BN_VIS: begin
                if (!vs_rdata && r_tail < (VAW + 1)'(NV)) begin
                    vs_we = 1'b1; vs_waddr = r_nb; vs_wdata = 1'b1;
                    qu_we = 1'b1; qu_waddr = r_tail[VAW-1:0]; qu_wdata = VW'(r_nb);
                    n_tail = r_tail + (VAW + 1)'(1);
                end
                n_st = S_BN_RD;
            end
            // Depth-first walk, top of stack held in registers
            S_D_START: begin
                vs_we = 1'b1; vs_waddr = w_src; vs_wdata = 1'b1;
                if (!r_path) begin
                    n_pend = VW'(w_src); n_pv = 1'b1;
                end
                n_tv = w_src; n_ts = '0; n_sp = (VAW + 1)'(1);
                dg_re = 1'b1; dg_raddr = w_src;
                n_st = S_D_DEG;
            end
            S_D_DEG: begin
                n_deg = r_deg_vld[r_tv] ? dg_rdata : DW'(0);
                n_st = S_D_TOP;
            end
            S_D_TOP: begin
                if (r_ts < r_deg) begin
                    nt_re = 1'b1; nt_raddr = nt_addr(r_tv, r_ts);
                    n_ts = r_ts + DW'(1);
                    n_st = S_D_NB;
                end else if (r_sp == (VAW + 1)'(1)) begin
                    n_fv = r_path ? VW'(0) : r_pend;
                    n_st = S_FIN;
                end else begin
                    sk_re = 1'b1; sk_raddr = w_sp_m2[VAW-1:0];
                    n_sp = w_sp_m1;
                    n_st = S_D_POP;
                end
            end
            S_D_POP: begin
                n_tv = sk_rdata[SW-1:DW]; n_ts = sk_rdata[DW-1:0];
                dg_re = 1'b1; dg_raddr = sk_rdata[SW-1:DW];
                n_st = S_D_DEG;
            end
            S_D_NB: begin
                n_nb = nt_rdata[VAW-1:0];
                if ({1'b0, nt_rdata} < w_n) begin
                    vs_re = 1'b1; vs_raddr = nt_rdata[VAW-1:0];
                    n_st = S_D_VIS;
                end else begin
                    n_st = S_D_TOP;
                end
            end
            S_D_VIS: begin
                if (vs_rdata) begin
                    n_st = S_D_TOP;
                end else if (r_path && r_nb == r_b[VAW-1:0]) begin
                    n_ff = 1'b1; n_st = S_FIN;
                end else if (!(!r_path && r_pv && !w_out_free)) begin
                    if (!r_path) begin
                        if (r_pv) begin
                            e_en = 1'b1; e_vert = r_pend;
                        end
                        n_pend = VW'(r_nb); n_pv = 1'b1;
                    end
                    vs_we = 1'b1; vs_waddr = r_nb; vs_wdata = 1'b1;
                    if (r_sp < (VAW + 1)'(NV)) begin
                        sk_we = 1'b1; sk_waddr = w_sp_m1[VAW-1:0]; sk_wdata = {r_tv, r_ts};
                        n_tv = r_nb; n_ts = '0;
                        n_sp = r_sp + (VAW + 1)'(1);
                        dg_re = 1'b1; dg_raddr = r_nb;
                        n_st = S_D_DEG;
                    end else begin
                        n_st = S_D_TOP;
                    end
                end
            end
            // Final word of the command
            S_FIN: begin
                if (w_out_free) begin
                    e_en = 1'b1; e_vert = r_fv; e_found = r_ff; e_stat = r_fs; e_last = 1'b1;
                    n_pv = 1'b0;
                    n_st = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_vc      <= gte_pkg::VC_RESET;
            r_deg_vld <= '0;
            r_pv      <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_st      <= n_st;
            r_deg_vld <= n_deg_vld;
            r_pv      <= n_pv;
            if (i_cfg_we) begin
                r_vc <= i_cfg_data;
            end
            if (e_en) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Working registers and output word
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_a <= n_a; r_b <= n_b; r_path <= n_path;
        r_da <= n_da; r_db <= n_db; r_cnt <= n_cnt;
        r_head <= n_head; r_tail <= n_tail; r_sp <= n_sp;
        r_f <= n_f; r_nb <= n_nb; r_tv <= n_tv;
        r_deg <= n_deg; r_j <= n_j; r_ts <= n_ts;
        r_pend <= n_pend; r_fv <= n_fv; r_ff <= n_ff; r_fs <= n_fs;
        if (e_en) begin
            r_o_vert  <= e_vert;
            r_o_found <= e_found;
            r_o_stat  <= e_stat;
            r_o_last  <= e_last;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_visited_vertex = r_o_vert;
    assign o_path_found     = r_o_found;
    assign o_status         = r_o_stat;
    assign o_last           = r_o_last;

    // Memories
    gte_ram #(.WIDTH(VW), .DEPTH(NV * MAX_DEGREE)) u_nt_ram (
        .i_clk(i_clk), .i_we(nt_we), .i_waddr(nt_waddr), .i_wdata(nt_wdata),
        .i_re(nt_re), .i_raddr(nt_raddr), .o_rdata(nt_rdata)
    );
    gte_ram #(.WIDTH(DW), .DEPTH(NV)) u_deg_ram (
        .i_clk(i_clk), .i_we(dg_we), .i_waddr(dg_waddr), .i_wdata(dg_wdata),
        .i_re(dg_re), .i_raddr(dg_raddr), .o_rdata(dg_rdata)
    );
    gte_ram #(.WIDTH(1), .DEPTH(NV)) u_vis_ram (
        .i_clk(i_clk), .i_we(vs_we), .i_waddr(vs_waddr), .i_wdata(vs_wdata),
        .i_re(vs_re), .i_raddr(vs_raddr), .o_rdata(vs_rdata)
    );
    gte_ram #(.WIDTH(VW), .DEPTH(NV)) u_queue_ram (
        .i_clk(i_clk), .i_we(qu_we), .i_waddr(qu_waddr), .i_wdata(qu_wdata),
        .i_re(qu_re), .i_raddr(qu_raddr), .o_rdata(qu_rdata)
    );
    gte_ram #(.WIDTH(SW), .DEPTH(NV)) u_stack_ram (
        .i_clk(i_clk), .i_we(sk_we), .i_waddr(sk_waddr), .i_wdata(sk_wdata),
        .i_re(sk_re), .i_raddr(sk_raddr), .o_rdata(sk_rdata)
    );

    // Checks
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_BQ_RD) |-> (r_head <= r_tail && r_tail <= (VAW + 1)'(NV)))
        else $error("walk queue head passed tail");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_D_TOP) |-> (r_sp != '0 && r_sp <= (VAW + 1)'(NV)))
        else $error("walk stack pointer out of bounds");

    a_no_pending_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE) |-> !r_pv)
        else $error("pending visit word left over in idle");

    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_FIN && w_out_free) |=> (o_out_valid && o_last && r_st == S_IDLE))
        else $error("final word not issued with last");

endmodule
